[src/json_string_unescape_utf8_core_macros.svh]
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define JSU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define JSU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/jsu_pkg.sv]
package jsu_pkg;

  localparam logic [15:0] JSU_CAP_RESET   = 16'd256;
  localparam int unsigned JSU_QUEUE_DEPTH = 4;
  localparam int unsigned JSU_OUT_DEPTH   = 4;

  // Characters with a meaning of their own in the string syntax.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BS_CTL = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  localparam logic [15:0] SUR_HIGH_MIN = 16'hD800;
  localparam logic [15:0] SUR_HIGH_MAX = 16'hDBFF;
  localparam logic [15:0] SUR_LOW_MIN  = 16'hDC00;
  localparam logic [15:0] SUR_LOW_MAX  = 16'hDFFF;
  localparam logic [20:0] CP_1B_LIM    = 21'h00080;
  localparam logic [20:0] CP_2B_LIM    = 21'h00800;
  localparam logic [20:0] CP_3B_LIM    = 21'h10000;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_value;
    logic       end_of_text;
  } jsu_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        done_res;
    logic [15:0] total_length;
    logic        last;
  } jsu_out_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } jsu_hex_t;

  // One classified text byte as it travels from the front end to the engine.
  typedef struct packed {
    logic [7:0] sym;
    logic       start;
    logic       eot;
    logic       hex_ok;
    logic [3:0] hex_val;
  } jsu_item_t;

  function automatic jsu_hex_t jsu_hex(input logic [7:0] c);
    jsu_hex_t   h;
    logic [7:0] d;
    h.ok  = 1'b0;
    h.val = 4'd0;
    d     = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      h = '{ok: 1'b1, val: d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      h = '{ok: 1'b1, val: d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      h = '{ok: 1'b1, val: d[3:0]};
    end
    return h;
  endfunction

endpackage

[src/jsu_fifo.sv]
module jsu_fifo import jsu_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = JSU_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

[src/jsu_front.sv]
module jsu_front import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  jsu_in_t   in_data,
  output logic      in_stall,
  output logic      dn_valid,
  output jsu_item_t dn_item,
  input  logic      dn_ready
);

  logic      vld_r, vld_nxt;
  jsu_item_t item_r, item_nxt;
  jsu_hex_t  hx;
  logic      take;

  assign in_stall = vld_r && !dn_ready;
  assign take     = in_valid && !in_stall;
  assign dn_valid = vld_r;
  assign dn_item  = item_r;

  // A zero byte ends the text just like the explicit end marker.
  always_comb begin
    hx       = jsu_hex(in_data.in_byte);
    item_nxt = '{sym:     in_data.in_byte,
                 start:   in_data.start_value,
                 eot:     in_data.end_of_text || (in_data.in_byte == CH_NUL),
                 hex_ok:  hx.ok,
                 hex_val: hx.val};
    vld_nxt  = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (dn_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (take) begin
        item_r <= item_nxt;
      end
    end
  end

endmodule

[src/jsu_back.sv]
`include "json_string_unescape_utf8_core_macros.svh"

module jsu_back import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] cap_i,
  input  logic        q_valid,
  input  jsu_item_t   q_item,
  output logic        q_pop,
  input  logic        out_full,
  output logic        out_push,
  output jsu_out_t    out_beat
);

  typedef enum logic [3:0] {
    PH_SEEK, PH_STR, PH_ESC, PH_HEX, PH_PAIR_BS, PH_PAIR_U, PH_PAIR_HEX, PH_FULL, PH_DONE
  } phase_t;

  phase_t      ph_r, ph_nxt, ph_b;
  logic [2:0]  hc_r, hc_nxt, hc_b;
  logic [15:0] acc_r, acc_nxt, acc_b, acc_n;
  logic [15:0] high_r, high_nxt, high_b;
  logic [15:0] len_r, len_nxt, len_b;
  logic [7:0]  held_r [6];
  logic [7:0]  held_nxt [6];
  logic [7:0]  bst_r [4];
  logic [7:0]  bst_nxt [4];
  logic [2:0]  bcnt_r, bcnt_nxt;
  logic [7:0]  rp_r [6];
  logic [7:0]  rp_nxt [6];
  logic [2:0]  rpc_r, rpc_nxt;
  logic        retake_r, retake_nxt;
  jsu_item_t   cur_r, cur_nxt;
  jsu_out_t    hold_r, hold_nxt;
  logic        hold_v_r, hold_v_nxt, hold_last_r, hold_last_nxt;

  logic [15:0] cap_e;
  logic        busy, adv, act, src_rp, src_re, clr, fin, busy_nxt;
  logic [7:0]  sym;
  logic        s_end, ws;
  jsu_hex_t    hx;
  logic        e_emit, e_fin, b_load, rp_load, res_v;
  logic [7:0]  e_byte;
  logic [20:0] b_code;
  logic [2:0]  enc_n;
  logic [7:0]  enc [4];
  jsu_out_t    res;

  always_comb begin
    cap_e  = (cap_i == '0) ? 16'd1 : cap_i;
    busy   = (bcnt_r != '0) || (rpc_r != '0) || retake_r;
    adv    = !out_full;
    act    = adv && (busy || q_valid);
    src_rp = (rpc_r != '0);
    src_re = !src_rp && retake_r;
    q_pop  = act && !busy;
    clr    = q_pop && q_item.start;

    if (src_rp) begin
      sym   = rp_r[0];
      s_end = 1'b0;
      hx    = jsu_hex(rp_r[0]);
    end else if (src_re) begin
      sym   = cur_r.sym;
      s_end = cur_r.eot;
      hx    = '{ok: cur_r.hex_ok, val: cur_r.hex_val};
    end else begin
      sym   = q_item.sym;
      s_end = q_item.eot;
      hx    = '{ok: q_item.hex_ok, val: q_item.hex_val};
    end
    ws = (sym == CH_SPACE) || (sym >= CH_TAB && sym <= CH_CR);

    ph_b   = clr ? PH_SEEK : ph_r;
    hc_b   = clr ? 3'd0 : hc_r;
    acc_b  = clr ? 16'd0 : acc_r;
    high_b = clr ? 16'd0 : high_r;
    len_b  = clr ? 16'd0 : len_r;
    acc_n  = {acc_b[11:0], hx.val};

    ph_nxt     = ph_b;
    hc_nxt     = hc_b;
    acc_nxt    = acc_b;
    high_nxt   = high_b;
    len_nxt    = len_b;
    held_nxt   = held_r;
    bst_nxt    = bst_r;
    bcnt_nxt   = bcnt_r;
    rp_nxt     = rp_r;
    rpc_nxt    = rpc_r;
    retake_nxt = retake_r;
    cur_nxt    = cur_r;

    e_emit  = 1'b0;
    e_fin   = 1'b0;
    e_byte  = 8'd0;
    b_load  = 1'b0;
    b_code  = 21'd0;
    rp_load = 1'b0;
    res_v   = 1'b0;
    res     = '{out_byte: 8'd0, done_res: 1'b0, total_length: len_b, last: 1'b0};

    if (act && (bcnt_r != '0)) begin
      // Drain one byte of a pending UTF-8 sequence.
      e_emit   = 1'b1;
      e_byte   = bst_r[0];
      bcnt_nxt = bcnt_r - 3'd1;
      for (int i = 0; i < 3; i++) begin
        bst_nxt[i] = bst_r[i + 1];
      end
    end else if (act) begin
      if (src_rp) begin
        rpc_nxt = rpc_r - 3'd1;
        for (int i = 0; i < 5; i++) begin
          rp_nxt[i] = rp_r[i + 1];
        end
      end else if (src_re) begin
        retake_nxt = 1'b0;
      end else begin
        cur_nxt    = q_item;
        retake_nxt = 1'b0;
      end

      case (ph_b)
        PH_DONE: begin
          ph_nxt = PH_DONE;
        end
        PH_FULL: begin
          e_fin = 1'b1;
        end
        PH_SEEK: begin
          if (s_end) begin
            e_fin = 1'b1;
          end else if (sym == CH_QUOTE) begin
            ph_nxt = (cap_e == 16'd1) ? PH_FULL : PH_STR;
          end else if (!ws) begin
            e_fin = 1'b1;
          end
        end
        PH_STR: begin
          if (s_end || sym == CH_QUOTE) begin
            e_fin = 1'b1;
          end else if (sym == CH_BSLASH) begin
            ph_nxt = PH_ESC;
          end else begin
            e_emit = 1'b1;
            e_byte = sym;
          end
        end
        PH_ESC: begin
          if (s_end) begin
            e_fin = 1'b1;
          end else begin
            ph_nxt = PH_STR;
            e_emit = 1'b1;
            case (sym)
              CH_LOW_N: e_byte = CH_LF;
              CH_LOW_T: e_byte = CH_TAB;
              CH_LOW_R: e_byte = CH_CR;
              CH_LOW_B: e_byte = CH_BS_CTL;
              CH_LOW_F: e_byte = CH_FF;
              CH_LOW_U: begin
                e_emit  = 1'b0;
                ph_nxt  = PH_HEX;
                hc_nxt  = 3'd0;
                acc_nxt = 16'd0;
              end
              default: e_byte = sym;
            endcase
          end
        end
        PH_HEX: begin
          if (!s_end && hx.ok) begin
            held_nxt[hc_b] = sym;
            acc_nxt        = acc_n;
            hc_nxt         = hc_b + 3'd1;
            if (hc_b == 3'd3) begin
              if (acc_n >= SUR_HIGH_MIN && acc_n <= SUR_HIGH_MAX) begin
                high_nxt = acc_n;
                ph_nxt   = PH_PAIR_BS;
              end else begin
                ph_nxt = PH_STR;
                b_load = 1'b1;
                b_code = {5'd0, acc_n};
              end
            end
          end else begin
            // Give back the 'u' and the digits seen so far as plain text.
            ph_nxt     = PH_STR;
            rp_load    = 1'b1;
            rp_nxt[0]  = CH_LOW_U;
            rp_nxt[1]  = held_r[0];
            rp_nxt[2]  = held_r[1];
            rp_nxt[3]  = held_r[2];
            rpc_nxt    = hc_b + 3'd1;
            retake_nxt = 1'b1;
          end
        end
        PH_PAIR_BS: begin
          if (!s_end && sym == CH_BSLASH) begin
            held_nxt[0] = CH_BSLASH;
            ph_nxt      = PH_PAIR_U;
          end else begin
            ph_nxt     = PH_STR;
            b_load     = 1'b1;
            b_code     = {5'd0, high_b};
            retake_nxt = 1'b1;
          end
        end
        PH_PAIR_U: begin
          if (!s_end && sym == CH_LOW_U) begin
            held_nxt[1] = CH_LOW_U;
            hc_nxt      = 3'd0;
            acc_nxt     = 16'd0;
            ph_nxt      = PH_PAIR_HEX;
          end else begin
            ph_nxt     = PH_STR;
            b_load     = 1'b1;
            b_code     = {5'd0, high_b};
            rp_load    = 1'b1;
            rp_nxt[0]  = held_r[0];
            rpc_nxt    = 3'd1;
            retake_nxt = 1'b1;
          end
        end
        PH_PAIR_HEX: begin
          if (!s_end && hx.ok) begin
            held_nxt[hc_b + 3'd2] = sym;
            acc_nxt               = acc_n;
            hc_nxt                = hc_b + 3'd1;
            if (hc_b == 3'd3) begin
              ph_nxt = PH_STR;
              b_load = 1'b1;
              if (acc_n >= SUR_LOW_MIN && acc_n <= SUR_LOW_MAX) begin
                b_code = CP_3B_LIM + {1'b0, high_b[9:0], acc_n[9:0]};
              end else begin
                // Not a low half: encode the high half alone, then rescan
                // the whole second escape as text.
                b_code  = {5'd0, high_b};
                rp_load = 1'b1;
                for (int i = 0; i < 5; i++) begin
                  rp_nxt[i] = held_r[i];
                end
                rp_nxt[5] = sym;
                rpc_nxt   = 3'd6;
              end
            end
          end else begin
            ph_nxt  = PH_STR;
            b_load  = 1'b1;
            b_code  = {5'd0, high_b};
            rp_load = 1'b1;
            for (int i = 0; i < 6; i++) begin
              rp_nxt[i] = held_r[i];
            end
            rpc_nxt    = hc_b + 3'd2;
            retake_nxt = 1'b1;
          end
        end
        default: begin
          ph_nxt = PH_DONE;
        end
      endcase
    end

    // UTF-8 form of a code point, lead byte first.
    enc[0] = b_code[7:0];
    enc[1] = 8'd0;
    enc[2] = 8'd0;
    enc[3] = 8'd0;
    if (b_code < CP_1B_LIM) begin
      enc_n = 3'd1;
    end else if (b_code < CP_2B_LIM) begin
      enc_n  = 3'd2;
      enc[0] = {3'b110, b_code[10:6]};
      enc[1] = {2'b10, b_code[5:0]};
    end else if (b_code < CP_3B_LIM) begin
      enc_n  = 3'd3;
      enc[0] = {4'b1110, b_code[15:12]};
      enc[1] = {2'b10, b_code[11:6]};
      enc[2] = {2'b10, b_code[5:0]};
    end else begin
      enc_n  = 3'd4;
      enc[0] = {5'b11110, b_code[20:18]};
      enc[1] = {2'b10, b_code[17:12]};
      enc[2] = {2'b10, b_code[11:6]};
      enc[3] = {2'b10, b_code[5:0]};
    end
    // A code point that does not fit the room left is dropped whole.
    if (b_load && (({1'b0, len_b} + {14'd0, enc_n}) < {1'b0, cap_e})) begin
      bst_nxt  = enc;
      bcnt_nxt = enc_n;
    end

    if (e_fin) begin
      res_v  = 1'b1;
      res    = '{out_byte: 8'd0, done_res: 1'b1, total_length: len_b, last: 1'b0};
      ph_nxt = PH_DONE;
    end else if (e_emit) begin
      res_v   = 1'b1;
      len_nxt = len_b + 16'd1;
      res     = '{out_byte: e_byte, done_res: 1'b0, total_length: len_nxt, last: 1'b0};
      if (({1'b0, len_b} + 17'd2) >= {1'b0, cap_e}) begin
        ph_nxt = PH_FULL;
      end
    end

    // The newest result waits in the hold register until it is known whether
    // it closes its input item.
    busy_nxt = (bcnt_nxt != '0) || (rpc_nxt != '0) || retake_nxt;
    fin      = act && !busy_nxt;
    out_push = adv && hold_v_r && (hold_last_r || res_v || fin);
    out_beat = '{out_byte:     hold_r.out_byte,
                 done_res:     hold_r.done_res,
                 total_length: hold_r.total_length,
                 last:         hold_last_r || !res_v};

    hold_nxt      = hold_r;
    hold_v_nxt    = hold_v_r;
    hold_last_nxt = hold_last_r;
    if (res_v) begin
      hold_nxt      = res;
      hold_v_nxt    = 1'b1;
      hold_last_nxt = fin;
    end else if (out_push) begin
      hold_v_nxt    = 1'b0;
      hold_last_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_SEEK;
      hc_r        <= 3'd0;
      acc_r       <= 16'd0;
      high_r      <= 16'd0;
      len_r       <= 16'd0;
      bcnt_r      <= 3'd0;
      rpc_r       <= 3'd0;
      retake_r    <= 1'b0;
      hold_v_r    <= 1'b0;
      hold_last_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      hc_r        <= hc_nxt;
      acc_r       <= acc_nxt;
      high_r      <= high_nxt;
      len_r       <= len_nxt;
      bcnt_r      <= bcnt_nxt;
      rpc_r       <= rpc_nxt;
      retake_r    <= retake_nxt;
      hold_v_r    <= hold_v_nxt;
      hold_last_r <= hold_last_nxt;
      held_r      <= held_nxt;
      bst_r       <= bst_nxt;
      rp_r        <= rp_nxt;
      cur_r       <= cur_nxt;
      hold_r      <= hold_nxt;
    end
  end

  `JSU_ASSERT_IMP(a_rp_load_idle, rp_load, rpc_r == 3'd0, "replay loaded over pending replay")
  `JSU_ASSERT_IMP(a_done_no_burst, ph_r == PH_DONE, bcnt_r == 3'd0, "UTF-8 bytes pending after done")
  `JSU_ASSERT_IMP(a_hex_count, ph_r == PH_HEX || ph_r == PH_PAIR_HEX, hc_r <= 3'd3,
                  "hex digit count out of range")
  `JSU_ASSERT_NXT(a_item_closed, fin, !hold_v_r || hold_last_r, "finished item left open result")

endmodule

[src/json_string_unescape_utf8_core.sv]
// JSON string value decoder. Text bytes of one value enter on the in_ channel
// (in_valid/in_stall, payload in_data), one byte per beat; start_value on a
// beat clears the decoder before that byte, and end_of_text (or a zero byte)
// ends the text. Decoded UTF-8 bytes leave on the out_ channel
// (out_valid/out_stall, payload out_data), closed by one done beat that
// carries the final length. last marks the final result beat of an input beat.
// cfg_we/cfg_wdata set the buffer capacity; write it only while idle.
// Path: each accepted beat passes the front-end register, the item queue,
// the engine and its hold register, and the output queue. A step that gives
// no result, such as the step that completes a \u escape, delays the results
// behind it. The decode engine runs one step per cycle while the output queue
// has room. It takes no new beat from the item queue while UTF-8 bytes, bytes
// that a broken escape gives back, or the byte that broke it are still pending;
// the given-back bytes are handled as text before the byte that broke it.
// Reset (synchronous, rst_n low) empties both queues, sets the capacity to
// 256 and puts the decoder back to seeking the opening quote.
// When the receiver stalls, the output queue fills, the engine holds, the
// input queue fills and in_stall rises; no beat is lost or repeated.
module json_string_unescape_utf8_core import jsu_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = JSU_QUEUE_DEPTH,
  parameter int unsigned OUT_DEPTH   = JSU_OUT_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  jsu_in_t     in_data,
  output logic        in_stall,
  output logic        out_valid,
  output jsu_out_t    out_data,
  input  logic        out_stall,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned ItemW = $bits(jsu_item_t);
  localparam int unsigned OutW  = $bits(jsu_out_t);

  // Capacity register: room for the string plus a terminator.
  logic [15:0] cap_r, cap_nxt;

  logic             fr_valid, fr_ready, q_full, q_empty, q_pop;
  jsu_item_t        fr_item, q_item;
  logic [ItemW-1:0] q_dout;
  logic             o_push, o_full, o_empty;
  jsu_out_t         o_beat;
  logic [OutW-1:0]  o_dout;

  assign cap_nxt = cfg_we ? cfg_wdata : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= JSU_CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  // Front end: takes a beat and classifies it (end marker, hex digit).
  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .dn_valid (fr_valid),
    .dn_item  (fr_item),
    .dn_ready (fr_ready)
  );

  assign fr_ready = !q_full;

  // Queue that decouples the front end from the decode engine.
  jsu_fifo #(
    .WIDTH (ItemW),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_valid),
    .din   (fr_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign q_item = jsu_item_t'(q_dout);

  // Decode engine: escapes, surrogate pairing, replay of held bytes, UTF-8.
  jsu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cap_i    (cap_r),
    .q_valid  (!q_empty),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_full (o_full),
    .out_push (o_push),
    .out_beat (o_beat)
  );

  // Output queue absorbs the bursts of a multi-byte code point.
  jsu_fifo #(
    .WIDTH (OutW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .din   (o_beat),
    .full  (o_full),
    .pop   (out_valid && !out_stall),
    .dout  (o_dout),
    .empty (o_empty)
  );

  assign out_valid = !o_empty;
  assign out_data  = jsu_out_t'(o_dout);

endmodule
